// ===== hw/rtl/kpsd_pkg.sv =====
package kpsd_pkg;

	localparam logic [5:0] DEBOUNCE_TICKS = 6'd32;
	localparam logic [5:0] IDLE_MARK      = 6'd33;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_ACK  = 1'b1;

	localparam logic [7:0] SEG_TABLE [32] = '{
		8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he0, 8'hfe, 8'hf6,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hee, 8'h3e, 8'h9c, 8'h7a, 8'h9e, 8'h8e,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef struct packed {
		logic [4:0] digit_four;
		logic [4:0] digit_three;
		logic [4:0] digit_two;
		logic [4:0] digit_one;
		logic [3:0] return_lines;
	} in_beat_t;

	typedef struct packed {
		logic [4:0] pad;
		logic       buzzer_request;
		logic       key_released;
		logic       key_valid;
		logic [3:0] pressed_key;
		logic [7:0] segment_drive;
		logic [3:0] scan_drive;
	} out_beat_t;

	typedef struct packed {
		logic [3:0] scan_position;
		logic [5:0] press_counter;
		logic [5:0] release_counter;
		logic [3:0] key_store;
		logic       ready_flag;
		logic       released_flag;
		logic       buzzer_flag;
		logic [3:0] scan_register;
		logic [7:0] segment_register;
	} scan_state_t;

	localparam scan_state_t STATE_RESET = '{
		scan_position:    4'd0,
		press_counter:    IDLE_MARK,
		release_counter:  DEBOUNCE_TICKS,
		key_store:        4'd0,
		ready_flag:       1'b0,
		released_flag:    1'b0,
		buzzer_flag:      1'b0,
		scan_register:    4'hf,
		segment_register: 8'hff
	};

endpackage

// ===== hw/rtl/kpsd_step.sv =====
module kpsd_step (
	input  kpsd_pkg::scan_state_t st,
	input  logic                  command,
	input  kpsd_pkg::in_beat_t    beat,
	output kpsd_pkg::scan_state_t st_next
);
	import kpsd_pkg::*;

	logic [1:0] sub;
	logic [1:0] grp;
	logic [4:0] idx;
	logic       level_high;
	logic [5:0] press_dec;
	logic [5:0] release_dec;

	always_comb begin
		sub         = st.scan_position[1:0];
		grp         = st.scan_position[3:2];
		level_high  = beat.return_lines[sub];
		press_dec   = st.press_counter - 6'd1;
		release_dec = st.release_counter - 6'd1;
		case (grp)
			2'd0:    idx = beat.digit_one;
			2'd1:    idx = beat.digit_two;
			2'd2:    idx = beat.digit_three;
			default: idx = beat.digit_four;
		endcase

		st_next = st;
		if (command == CMD_ACK) begin
			if (st.released_flag) begin
				st_next.ready_flag    = 1'b0;
				st_next.released_flag = 1'b0;
			end
		end else begin
			if (sub == 2'd0) begin
				st_next.scan_register    = ~(4'b0001 << grp);
				st_next.segment_register = SEG_TABLE[idx];
			end else if (sub == 2'd3) begin
				st_next.segment_register = 8'h00;
			end

			if (st.ready_flag) begin
				if (!level_high) begin
					st_next.release_counter = DEBOUNCE_TICKS;
				end else if (release_dec == 6'd0) begin
					st_next.released_flag   = 1'b1;
					st_next.buzzer_flag     = 1'b0;
					st_next.release_counter = DEBOUNCE_TICKS;
				end else begin
					st_next.release_counter = release_dec;
				end
			end else if (st.press_counter == IDLE_MARK) begin
				if (!level_high) begin
					st_next.press_counter = press_dec;
					st_next.key_store     = st.scan_position;
				end
			end else if (press_dec == 6'd0) begin
				if (!level_high) begin
					st_next.ready_flag  = 1'b1;
					st_next.buzzer_flag = 1'b1;
				end
				st_next.press_counter = IDLE_MARK;
			end else begin
				st_next.press_counter = press_dec;
			end

			st_next.scan_position = st.scan_position + 4'd1;
		end
	end

endmodule

// ===== hw/rtl/keypad_scan_debounce_display_mux.sv =====
// 4x4 keypad scanner with press/release debounce and a four-digit
// seven-segment display multiplexer.
// Slave side: one beat per scan tick or acknowledge. s_tuser selects the
// command (0 = scan tick, 1 = acknowledge after release); s_tdata carries
// the return line levels and the four digit table indices.
// Master side: one beat per slave beat, carrying the scan line and segment
// levels, the last key position and the key_valid, key_released and
// buzzer_request flags as they stand after that beat.
// The result reaches m_tvalid through an input register and a result
// register. Throughput: one beat per cycle while m_tready does not stall;
// the scan and debounce update is a combinational step.
// Reset: all lines high, segments 0xff, counters idle, flags clear, both
// channels empty.
// A stall on m_tready holds the result register and the input register;
// s_tready drops only once both are full.
module keypad_scan_debounce_display_mux (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // return_lines, digit_one, digit_two, digit_three, digit_four
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // scan_drive, segment_drive, pressed_key, key_valid,
	                               // key_released, buzzer_request, zero padding
);
	import kpsd_pkg::*;

	logic        valid_s1;
	in_beat_t    beat_s1;
	logic        cmd_s1;
	logic        out_valid_q;
	out_beat_t   out_q;
	scan_state_t st_q;
	scan_state_t st_next;
	logic        out_free;
	logic        advance;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	kpsd_step u_step (
		.st      (st_q),
		.command (cmd_s1),
		.beat    (beat_s1),
		.st_next (st_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			beat_s1 <= in_beat_t'(s_tdata);
			cmd_s1  <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				st_q <= st_next;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.pad            <= 5'd0;
			out_q.buzzer_request <= st_next.buzzer_flag;
			out_q.key_released   <= st_next.released_flag;
			out_q.key_valid      <= st_next.ready_flag;
			out_q.pressed_key    <= st_next.key_store;
			out_q.segment_drive  <= st_next.segment_register;
			out_q.scan_drive     <= st_next.scan_register;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = 24'(out_q);

	a_scan_one_low: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(~st_q.scan_register)) else $error("more than one scan line low");

	a_buzzer_ready: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.buzzer_flag |-> st_q.ready_flag) else $error("buzzer without ready key");

	a_released_ready: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.released_flag |-> st_q.ready_flag) else $error("release without ready key");

	a_press_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.press_counter <= IDLE_MARK) else $error("press counter out of range");

endmodule
